// ----- rtl/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_pkg: shared constants for surface probe placement
// Field widths, grid default, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int unsigned GRID_EDGE_DEF = 32;

  localparam int unsigned COORD_W   = 5;
  localparam int unsigned SIZE_W    = 6;
  localparam int unsigned EDGE_W    = 5;
  localparam int unsigned COUNT_W   = 15;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_EDGE = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RST = 6'd32;
  localparam logic [EDGE_W-1:0] EDGE_RST = 5'd1;

  // 0.3 world units in Q8
  localparam int signed OFFSET_Q8 = 77;
  localparam int signed POS_MAX   = 131071;

endpackage

// ----- rtl/spp_in_if.sv -----
// ----------------------------------------------------------------------------
// spp_in_if: input item channel
// Valid/ready channel carrying one write or examine item.
// ----------------------------------------------------------------------------
interface spp_in_if;
  import spp_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COORD_W-1:0] vox_x;
  logic [COORD_W-1:0] vox_y;
  logic [COORD_W-1:0] vox_z;
  logic               occupied;
  logic               restart_count;

  modport source (output valid, kind, vox_x, vox_y, vox_z, occupied, restart_count,
                  input ready);
  modport sink (input valid, kind, vox_x, vox_y, vox_z, occupied, restart_count,
                output ready);
endinterface

// ----- rtl/spp_out_if.sv -----
// ----------------------------------------------------------------------------
// spp_out_if: result item channel
// Valid/ready channel carrying one examine result.
// ----------------------------------------------------------------------------
interface spp_out_if;
  import spp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    is_probe;
  logic [COUNT_W-1:0]      probe_number;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic [POS_W-1:0]        pos_x;
  logic [POS_W-1:0]        pos_y;
  logic [POS_W-1:0]        pos_z;

  modport source (output valid, is_probe, probe_number, dir_x, dir_y, dir_z,
                  pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, is_probe, probe_number, dir_x, dir_y, dir_z,
                pos_x, pos_y, pos_z, output ready);
endinterface

// ----- rtl/spp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// spp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface spp_cfg_if;
  import spp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ----- rtl/spp_ram.sv -----
// ----------------------------------------------------------------------------
// spp_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/spp_place.sv -----
// ----------------------------------------------------------------------------
// spp_place: probe position along one axis
// Voxel centre plus the Q8 offset times direction, clamped to the field range.
// ----------------------------------------------------------------------------
module spp_place (
  input  logic [spp_pkg::COORD_W-1:0]      v,
  input  logic signed [spp_pkg::DIR_W-1:0] d,
  input  logic [spp_pkg::EDGE_W-1:0]       cell_edge,
  output logic [spp_pkg::POS_W-1:0]        pos
);
  import spp_pkg::*;

  logic [COORD_W:0]          odd;
  logic [COORD_W+EDGE_W:0]   prod;
  logic signed [POS_W+1:0]   centre;
  logic signed [POS_W+1:0]   offs;
  logic signed [POS_W+1:0]   sum;

  always_comb begin
    odd    = {v, 1'b1};
    prod   = (COORD_W+EDGE_W+1)'(odd) * (COORD_W+EDGE_W+1)'(cell_edge);
    centre = $signed({1'b0, prod, 7'b0});
    case (d)
      2'sb01:  offs = (POS_W+2)'(OFFSET_Q8);
      2'sb11:  offs = -(POS_W+2)'(OFFSET_Q8);
      default: offs = '0;
    endcase
    sum = centre + offs;
    if (sum < 0) begin
      pos = '0;
    end else if (sum > (POS_W+2)'(POS_MAX)) begin
      pos = POS_W'(POS_MAX);
    end else begin
      pos = sum[POS_W-1:0];
    end
  end

endmodule

// ----- rtl/surface_probe_placement_core.sv -----
// ----------------------------------------------------------------------------
// surface_probe_placement_core: voxel bitmap and surface probe finder
// Stores occupancy bits of a 3-D grid and turns free voxels that touch an
// occupied face neighbour into numbered probes with direction and position.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_bus    in   valid/ready    kind, vox_x/y/z, occupied, restart_count
// out_bus   out  valid/ready    is_probe, probe_number, dir_x/y/z, pos_x/y/z
// cfg_bus   in   valid/ready    reg_index, data (always ready)
//
// A write item passes through a single write state; an examine makes 7 reads of the
// one-port bitmap RAM (one per cycle, with registered read data), then 3
// passes through the shared placement unit, then the result load.
// After reset a clearing pass writes all GRID_EDGE^3 entries (32768 at the default)
// before the first item is taken. A stalled result holds the block in its
// final step of the next examine; no item is accepted while it waits there.
// ----------------------------------------------------------------------------
module surface_probe_placement_core #(
  parameter int unsigned GRID_EDGE = spp_pkg::GRID_EDGE_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  spp_in_if.sink  in_bus,
  spp_out_if.source out_bus,
  spp_cfg_if.sink cfg_bus
);
  import spp_pkg::*;

  localparam int unsigned MAP_DEPTH = GRID_EDGE * GRID_EDGE * GRID_EDGE;
  localparam int unsigned AW        = $clog2(MAP_DEPTH);
  localparam int unsigned GG        = GRID_EDGE * GRID_EDGE;

  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_ZP     = 3'd1;
  localparam logic [2:0] STEP_ZN     = 3'd2;
  localparam logic [2:0] STEP_XP     = 3'd3;
  localparam logic [2:0] STEP_XN     = 3'd4;
  localparam logic [2:0] STEP_YP     = 3'd5;
  localparam logic [2:0] STEP_YN     = 3'd6;
  localparam logic [2:0] STEP_LAST   = 3'd7;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_WRITE = 6'b000100,
    ST_READ  = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  function automatic logic signed [DIR_W-1:0] dir_of(input logic p, input logic n);
    if (p && !n) begin
      return 2'sb01;
    end else if (n && !p) begin
      return 2'sb11;
    end
    return 2'sb00;
  endfunction

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic [EDGE_W-1:0]  cell_edge_r;
  logic [COORD_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic               occ_in_r, occ_in_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic [6:0]         occ_r, occ_nxt;
  logic               pend_inb_r, pend_inb_nxt;
  logic               cen_inb_r, cen_inb_nxt;
  logic [POS_W-1:0]   pos_r [3];
  logic [POS_W-1:0]   pos_nxt [3];

  logic                    ov_r, ov_nxt;
  logic                    o_probe_r, o_probe_nxt;
  logic [COUNT_W-1:0]      o_num_r, o_num_nxt;
  logic signed [DIR_W-1:0] o_dx_r, o_dy_r, o_dz_r, o_dx_nxt, o_dy_nxt, o_dz_nxt;
  logic [POS_W-1:0]        o_px_r, o_py_r, o_pz_r, o_px_nxt, o_py_nxt, o_pz_nxt;

  logic [SIZE_W-1:0]       eff_x, eff_y, eff_z;
  logic signed [6:0]       ox, oy, oz, nx, ny, nz;
  logic                    nb_inb;
  logic [AW-1:0]           nb_addr;
  logic                    ram_en, ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]           ram_addr;
  logic signed [DIR_W-1:0] dx, dy, dz, pl_d;
  logic [COORD_W-1:0]      pl_v;
  logic [POS_W-1:0]        pl_pos;
  logic                    probe;
  logic                    in_acc;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_acc        = in_bus.valid && in_bus.ready;

  assign eff_x = ({2'b00, size_x_r} > 8'(GRID_EDGE)) ? SIZE_W'(GRID_EDGE) : size_x_r;
  assign eff_y = ({2'b00, size_y_r} > 8'(GRID_EDGE)) ? SIZE_W'(GRID_EDGE) : size_y_r;
  assign eff_z = ({2'b00, size_z_r} > 8'(GRID_EDGE)) ? SIZE_W'(GRID_EDGE) : size_z_r;

  always_comb begin
    ox = '0;
    oy = '0;
    oz = '0;
    case (step_r)
      STEP_ZP: oz = 7'sd1;
      STEP_ZN: oz = -7'sd1;
      STEP_XP: ox = 7'sd1;
      STEP_XN: ox = -7'sd1;
      STEP_YP: oy = 7'sd1;
      STEP_YN: oy = -7'sd1;
      default: ;
    endcase
    nx = $signed({2'b00, x_r}) + ox;
    ny = $signed({2'b00, y_r}) + oy;
    nz = $signed({2'b00, z_r}) + oz;
    nb_inb = !nx[6] && !ny[6] && !nz[6] &&
             (nx[5:0] < eff_x) && (ny[5:0] < eff_y) && (nz[5:0] < eff_z);
    nb_addr = AW'(32'(nx[4:0]) * GG + 32'(ny[4:0]) * GRID_EDGE + 32'(nz[4:0]));
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = nb_addr;
    ram_wdata = occ_in_r;
    case (state_r)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = 1'b0;
      end
      ST_WRITE: begin
        ram_en = nb_inb;
        ram_we = 1'b1;
      end
      ST_READ: begin
        ram_en = nb_inb && (step_r != STEP_LAST);
      end
      default: ;
    endcase
  end

  spp_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign dz    = dir_of(occ_r[STEP_ZP], occ_r[STEP_ZN]);
  assign dx    = dir_of(occ_r[STEP_XP], occ_r[STEP_XN]);
  assign dy    = dir_of(occ_r[STEP_YP], occ_r[STEP_YN]);
  assign probe = cen_inb_r && !occ_r[STEP_CENTER] && (|occ_r[6:1]);

  always_comb begin
    case (axis_r)
      AXIS_X:  begin pl_v = x_r; pl_d = dx; end
      AXIS_Y:  begin pl_v = y_r; pl_d = dy; end
      default: begin pl_v = z_r; pl_d = dz; end
    endcase
  end

  spp_place u_place (
    .v         (pl_v),
    .d         (pl_d),
    .cell_edge (cell_edge_r),
    .pos       (pl_pos)
  );

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    occ_in_nxt   = occ_in_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    step_nxt     = step_r;
    axis_nxt     = axis_r;
    occ_nxt      = occ_r;
    pend_inb_nxt = pend_inb_r;
    cen_inb_nxt  = cen_inb_r;
    pos_nxt      = pos_r;
    ov_nxt       = ov_r && !out_bus.ready;
    o_probe_nxt  = o_probe_r;
    o_num_nxt    = o_num_r;
    o_dx_nxt     = o_dx_r;
    o_dy_nxt     = o_dy_r;
    o_dz_nxt     = o_dz_r;
    o_px_nxt     = o_px_r;
    o_py_nxt     = o_py_r;
    o_pz_nxt     = o_pz_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = STEP_CENTER;
        if (in_acc) begin
          x_nxt      = in_bus.vox_x;
          y_nxt      = in_bus.vox_y;
          z_nxt      = in_bus.vox_z;
          occ_in_nxt = in_bus.occupied;
          if (in_bus.kind) begin
            if (in_bus.restart_count) begin
              cnt_nxt = '0;
            end
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        pend_inb_nxt = nb_inb;
        if (step_r == STEP_CENTER) begin
          cen_inb_nxt = nb_inb;
        end else begin
          occ_nxt[step_r - 3'd1] = ram_rdata && pend_inb_r;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          axis_nxt  = AXIS_X;
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        pos_nxt[axis_r] = pl_pos;
        axis_nxt        = axis_r + 2'd1;
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ov_r || out_bus.ready) begin
          ov_nxt      = 1'b1;
          o_probe_nxt = probe;
          if (probe) begin
            o_num_nxt = cnt_r;
            o_dx_nxt  = dx;
            o_dy_nxt  = dy;
            o_dz_nxt  = dz;
            o_px_nxt  = pos_r[AXIS_X];
            o_py_nxt  = pos_r[AXIS_Y];
            o_pz_nxt  = pos_r[AXIS_Z];
            cnt_nxt   = cnt_r + COUNT_W'(1);
          end else begin
            o_num_nxt = '0;
            o_dx_nxt  = '0;
            o_dy_nxt  = '0;
            o_dz_nxt  = '0;
            o_px_nxt  = '0;
            o_py_nxt  = '0;
            o_pz_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ov_r        <= 1'b0;
      step_r      <= STEP_CENTER;
      axis_r      <= AXIS_X;
      size_x_r    <= SIZE_RST;
      size_y_r    <= SIZE_RST;
      size_z_r    <= SIZE_RST;
      cell_edge_r <= EDGE_RST;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.reg_index)
          CFG_SIZE_X:    size_x_r    <= cfg_bus.data;
          CFG_SIZE_Y:    size_y_r    <= cfg_bus.data;
          CFG_SIZE_Z:    size_z_r    <= cfg_bus.data;
          CFG_CELL_EDGE: cell_edge_r <= cfg_bus.data[EDGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    occ_in_r   <= occ_in_nxt;
    occ_r      <= occ_nxt;
    pend_inb_r <= pend_inb_nxt;
    cen_inb_r  <= cen_inb_nxt;
    pos_r      <= pos_nxt;
    o_probe_r  <= o_probe_nxt;
    o_num_r    <= o_num_nxt;
    o_dx_r     <= o_dx_nxt;
    o_dy_r     <= o_dy_nxt;
    o_dz_r     <= o_dz_nxt;
    o_px_r     <= o_px_nxt;
    o_py_r     <= o_py_nxt;
    o_pz_r     <= o_pz_nxt;
  end

  assign out_bus.valid        = ov_r;
  assign out_bus.is_probe     = o_probe_r;
  assign out_bus.probe_number = o_num_r;
  assign out_bus.dir_x        = o_dx_r;
  assign out_bus.dir_y        = o_dy_r;
  assign out_bus.dir_z        = o_dz_r;
  assign out_bus.pos_x        = o_px_r;
  assign out_bus.pos_y        = o_py_r;
  assign out_bus.pos_z        = o_pz_r;

endmodule

// ----- bench/spp_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_tb_pkg: bench-side types for surface probe placement
// Item kind codes and the packed form of one expected probe result.
// ----------------------------------------------------------------------------
package spp_tb_pkg;
  import spp_pkg::*;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_EXAMINE = 1'b1;

  typedef struct packed {
    logic                    is_probe;
    logic [COUNT_W-1:0]      probe_number;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic [POS_W-1:0]        pos_z;
  } probe_res_t;

endpackage

// ----- bench/spp_probe_checker.sv -----
// ----------------------------------------------------------------------------
// spp_probe_checker: result predictor and comparator
// Watches the item, result and register channels, keeps its own occupancy
// map, probe counter and register copies, predicts each examine result and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spp_probe_checker (
  input  logic clk,
  input  logic rst_n,
  spp_in_if    in_mon,
  spp_out_if   out_mon,
  spp_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  import spp_pkg::*;
  import spp_tb_pkg::*;

  localparam int EDGE_N = GRID_EDGE_DEF;

  bit [EDGE_N*EDGE_N*EDGE_N-1:0] occ_map;
  logic [COUNT_W-1:0]            probe_count;
  logic [SIZE_W-1:0]             size_x_q, size_y_q, size_z_q;
  logic [EDGE_W-1:0]             cell_edge_q;
  probe_res_t                    probe_q[$];

  function automatic int span(logic [SIZE_W-1:0] s);
    return (s > EDGE_N) ? EDGE_N : int'(s);
  endfunction

  function automatic bit in_box(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < span(size_x_q) && y < span(size_y_q) && z < span(size_z_q);
  endfunction

  function automatic int voxel_index(int x, int y, int z);
    return (x * EDGE_N + y) * EDGE_N + z;
  endfunction

  function automatic bit occ_at(int x, int y, int z);
    if (!in_box(x, y, z)) return 1'b0;
    return occ_map[voxel_index(x, y, z)];
  endfunction

  function automatic logic [POS_W-1:0] place_axis(int v, int d);
    int p;
    p = (2 * v + 1) * int'(cell_edge_q) * 128 + d * OFFSET_Q8;
    if (p < 0) p = 0;
    if (p > POS_MAX) p = POS_MAX;
    return p[POS_W-1:0];
  endfunction

  function automatic probe_res_t examine_voxel(int x, int y, int z, logic restart);
    probe_res_t r;
    int dx, dy, dz;
    bit touch;
    r = '0;
    dx = 0;
    dy = 0;
    dz = 0;
    touch = 1'b0;
    if (restart) probe_count = '0;
    if (!in_box(x, y, z) || occ_at(x, y, z)) return r;
    if (occ_at(x, y, z + 1)) begin dz++; touch = 1'b1; end
    if (occ_at(x, y, z - 1)) begin dz--; touch = 1'b1; end
    if (occ_at(x + 1, y, z)) begin dx++; touch = 1'b1; end
    if (occ_at(x - 1, y, z)) begin dx--; touch = 1'b1; end
    if (occ_at(x, y + 1, z)) begin dy++; touch = 1'b1; end
    if (occ_at(x, y - 1, z)) begin dy--; touch = 1'b1; end
    if (!touch) return r;
    r.is_probe     = 1'b1;
    r.probe_number = probe_count;
    r.dir_x        = dx[DIR_W-1:0];
    r.dir_y        = dy[DIR_W-1:0];
    r.dir_z        = dz[DIR_W-1:0];
    r.pos_x        = place_axis(x, dx);
    r.pos_y        = place_axis(y, dy);
    r.pos_z        = place_axis(z, dz);
    probe_count    = probe_count + 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    probe_res_t want;
    if (rst_n !== 1'b1) begin
      occ_map     = '0;
      probe_count = '0;
      size_x_q    = SIZE_RST;
      size_y_q    = SIZE_RST;
      size_z_q    = SIZE_RST;
      cell_edge_q = EDGE_RST;
      probe_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (probe_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, expected none actual is_probe %0d",
                   $time, out_mon.is_probe);
        end else begin
          want = probe_q.pop_front();
          check_field("is_probe", want.is_probe, out_mon.is_probe);
          check_field("probe_number", want.probe_number, out_mon.probe_number);
          check_field("dir_x", want.dir_x, out_mon.dir_x);
          check_field("dir_y", want.dir_y, out_mon.dir_y);
          check_field("dir_z", want.dir_z, out_mon.dir_z);
          check_field("pos_x", want.pos_x, out_mon.pos_x);
          check_field("pos_y", want.pos_y, out_mon.pos_y);
          check_field("pos_z", want.pos_z, out_mon.pos_z);
        end
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.reg_index)
          CFG_SIZE_X:    size_x_q = cfg_mon.data;
          CFG_SIZE_Y:    size_y_q = cfg_mon.data;
          CFG_SIZE_Z:    size_z_q = cfg_mon.data;
          CFG_CELL_EDGE: cell_edge_q = cfg_mon.data[EDGE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.kind == KIND_WRITE) begin
          if (in_box(in_mon.vox_x, in_mon.vox_y, in_mon.vox_z))
            occ_map[voxel_index(in_mon.vox_x, in_mon.vox_y, in_mon.vox_z)] = in_mon.occupied;
        end else begin
          probe_q.push_back(examine_voxel(in_mon.vox_x, in_mon.vox_y, in_mon.vox_z,
                                          in_mon.restart_count));
        end
      end
    end
    pending = probe_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level for surface_probe_placement_core
// Drives directed and random write/examine items under several register
// settings with bursty sending and random result stalls, ends with a short
// back-to-back probe stream, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import spp_pkg::*;
  import spp_tb_pkg::*;

  localparam int SETTLE       = 32;
  localparam int WATCHDOG     = 140000;
  localparam int HOLD_OFF     = 400;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int STREAM_ITEMS = 16;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;

  spp_in_if  in_if ();
  spp_out_if out_if ();
  spp_cfg_if cfg_if ();

  surface_probe_placement_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  spp_probe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fails),
    .pending    (pending)
  );

  bit                gaps_on;
  bit                rx_fast;
  int                burst_left;
  int                hold_ticket;
  int                hold_seen;
  int                hold_left;
  int                rx_mode_left;
  int                rx_pct;
  int                idle_cycles;
  int                cx, cy, cz;
  logic [SIZE_W-1:0] cur_sx, cur_sy, cur_sz;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else if (rx_fast) begin
      out_if.ready = 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: rx_pct = 100;
          1: rx_pct = 75;
          2: rx_pct = 50;
          default: rx_pct = 20;
        endcase
      end
      rx_mode_left--;
      out_if.ready = (int'($urandom_range(0, 99)) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
          (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  function automatic int span_of(logic [SIZE_W-1:0] s);
    return (s > GRID_EDGE_DEF) ? GRID_EDGE_DEF : int'(s);
  endfunction

  task automatic send_item(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic occ, logic restart);
    if (gaps_on && burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid         = 1'b1;
    in_if.kind          = kind;
    in_if.vox_x         = x;
    in_if.vox_y         = y;
    in_if.vox_z         = z;
    in_if.occupied      = occ;
    in_if.restart_count = restart;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_voxel(int x, int y, int z, logic occ);
    send_item(KIND_WRITE, x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0], occ, 1'b0);
  endtask

  task automatic probe_at(int x, int y, int z, logic restart);
    send_item(KIND_EXAMINE, x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0], 1'b0, restart);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_if.valid     = 1'b1;
    cfg_if.reg_index = idx;
    cfg_if.data      = value;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic pick_center();
    cx = (span_of(cur_sx) > 0) ? $urandom_range(0, span_of(cur_sx) - 1) : 0;
    cy = (span_of(cur_sy) > 0) ? $urandom_range(0, span_of(cur_sy) - 1) : 0;
    cz = (span_of(cur_sz) > 0) ? $urandom_range(0, span_of(cur_sz) - 1) : 0;
  endtask

  task automatic configure(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                           logic [SIZE_W-1:0] sz, logic [CFG_DAT_W-1:0] cell_data);
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_CELL_EDGE, cell_data);
    cur_sx = sx;
    cur_sy = sy;
    cur_sz = sz;
    pick_center();
  endtask

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_cell();
    logic [EDGE_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = '0;
      1: c = 5'd16;
      2: c = 5'd31;
      3: c = 5'($urandom_range(17, 31));
      default: c = 5'($urandom_range(1, 8));
    endcase
    return {1'($urandom), c};
  endfunction

  function automatic int near(int c, int s);
    int v;
    if (s == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 31);
    v = c + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > s - 1) v = s - 1;
    return v;
  endfunction

  task automatic random_item();
    int x, y, z;
    if ($urandom_range(0, 9) == 0) begin
      send_item(1'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                1'($urandom), 1'($urandom));
    end else begin
      x = near(cx, span_of(cur_sx));
      y = near(cy, span_of(cur_sy));
      z = near(cz, span_of(cur_sz));
      send_item(($urandom_range(0, 99) < 45) ? KIND_WRITE : KIND_EXAMINE,
                x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0],
                $urandom_range(0, 99) < 55, $urandom_range(0, 29) == 0);
    end
  endtask

  initial begin
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_WRITE;
    in_if.vox_x         = '0;
    in_if.vox_y         = '0;
    in_if.vox_z         = '0;
    in_if.occupied      = 1'b0;
    in_if.restart_count = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = CFG_SIZE_X;
    cfg_if.data         = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    gaps_on             = 1'b0;
    rx_fast             = 1'b0;
    burst_left          = 0;
    hold_ticket         = 0;
    hold_seen           = 0;
    hold_left           = 0;
    rx_mode_left        = 0;
    rx_pct              = 100;
    idle_cycles         = 0;
    cur_sx              = SIZE_RST;
    cur_sy              = SIZE_RST;
    cur_sz              = SIZE_RST;
    cx = 0;
    cy = 0;
    cz = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: single neighbours, cancellation, clear, grid corners
    probe_at(0, 0, 0, 1'b1);
    put_voxel(5, 5, 5, 1'b1);
    probe_at(5, 5, 6, 1'b0);
    probe_at(5, 5, 4, 1'b0);
    probe_at(4, 5, 5, 1'b0);
    probe_at(6, 5, 5, 1'b0);
    probe_at(5, 4, 5, 1'b0);
    probe_at(5, 6, 5, 1'b0);
    probe_at(5, 5, 5, 1'b0);
    put_voxel(5, 5, 7, 1'b1);
    probe_at(5, 5, 6, 1'b0);
    put_voxel(5, 5, 7, 1'b0);
    probe_at(5, 5, 6, 1'b0);
    put_voxel(31, 31, 31, 1'b1);
    probe_at(31, 31, 30, 1'b0);
    probe_at(31, 30, 31, 1'b0);
    put_voxel(0, 0, 0, 1'b1);
    probe_at(1, 0, 0, 1'b0);
    probe_at(0, 0, 1, 1'b1);
    send_item(KIND_WRITE, 5'd0, 5'd1, 5'd0, 1'b0, 1'b1);
    probe_at(0, 1, 0, 1'b0);

    // zero cell edge, small box, outside voxels and neighbours
    configure(6'd4, 6'd4, 6'd4, 6'd0);
    probe_at(1, 0, 0, 1'b0);
    put_voxel(31, 31, 31, 1'b0);
    probe_at(31, 31, 31, 1'b0);
    put_voxel(3, 3, 3, 1'b1);
    probe_at(3, 3, 2, 1'b0);

    // oversized box, largest cell edge
    configure(6'd63, 6'd63, 6'd63, 6'd31);
    probe_at(31, 31, 30, 1'b0);
    probe_at(31, 30, 31, 1'b0);

    // empty box
    configure(6'd0, 6'd0, 6'd0, 6'd16);
    put_voxel(2, 2, 2, 1'b1);
    probe_at(0, 0, 1, 1'b0);

    configure(6'd32, 6'd32, 6'd32, 6'd33);
    probe_at(31, 31, 30, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(rand_size(), rand_size(), rand_size(), rand_cell());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 39) pick_center();
        if (p == 3 && i == 60) begin
          gaps_on = 1'b0;
          hold_ticket++;
        end
        if (p == 5 && i == 75) drain();
        random_item();
      end
    end

    // back-to-back probes with a fast receiver
    configure(6'd3, 6'd3, 6'd3, 6'd2);
    put_voxel(0, 0, 0, 1'b1);
    put_voxel(0, 0, 1, 1'b0);
    gaps_on = 1'b0;
    rx_fast = 1'b1;
    probe_at(0, 0, 1, 1'b1);
    repeat (STREAM_ITEMS) probe_at(0, 0, 1, 1'b0);
    drain();
    rx_fast = 1'b0;

    repeat (SETTLE) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
